// File: design/lbsm_pkg.sv
// Shared types for the LRU buffer slot manager.
// Request/result payloads, stored tag word and controller/datapath handshake.
// No dependencies.
package lbsm_pkg;

	// Width of the reported slot index field
	localparam int SLOT_W = 4;

	// Request command codes
	localparam logic CMD_FETCH = 1'b0;
	localparam logic CMD_BLANK = 1'b1;

	typedef struct packed {
		logic        command;
		logic [15:0] table_id;
		logic [15:0] file_id;
		logic [23:0] block_offset;
	} req_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic              hit;
		logic              replaced;
		logic [15:0]       old_table_id;
		logic [15:0]       old_file_id;
		logic [23:0]       old_block_offset;
	} rsp_t;

	// One stored slot tag
	typedef struct packed {
		logic [15:0] table_id;
		logic [15:0] file_id;
		logic        file_valid;
		logic [23:0] block_offset;
	} tag_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic scan;
		logic commit;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic last;
	} stat_t;

endpackage

// File: design/lbsm_ctrl.sv
// Sequencing controller for the LRU buffer slot manager.
// Steps accept, slot scan, final compare and commit; drives busy and done.
// Depends on lbsm_pkg.
module lbsm_ctrl import lbsm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  stat_t stat,
	output cmd_t  cmd,
	output logic  busy,
	output logic  done
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_LAST   = 2'd2;
	localparam logic [1:0] ST_COMMIT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       done_q;

	// Next state and commands
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.last) begin
					state_d = ST_LAST;
				end
			end
			ST_LAST: begin
				state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold state and raise the result strobe after commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.commit;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

endmodule

// File: design/lbsm_datapath.sv
// Datapath for the LRU buffer slot manager: tag and age memories, used bits,
// scan trackers for hit, first free slot and oldest slot, and result register.
// Depends on lbsm_pkg.
module lbsm_datapath import lbsm_pkg::*; #(
	parameter int SLOTS    = 16,
	parameter int AGE_BITS = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	input  cmd_t  cmd,
	input  req_t  req,
	output stat_t stat,
	output rsp_t  rsp
);

	localparam int IW = $clog2(SLOTS);
	localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

	// Slot storage; contents of never-used slots are never observed
	tag_t              tag_mem [SLOTS];
	logic [AGE_BITS-1:0] age_mem [SLOTS];
	logic [SLOTS-1:0]  used_q;

	req_t              req_q;
	logic [IW-1:0]     cnt_q;
	logic              rd_valid_s1;
	logic [IW-1:0]     idx_s1;
	tag_t              tag_s1;
	logic [AGE_BITS-1:0] age_s1;

	logic              hit_found_q;
	logic [IW-1:0]     hit_idx_q;
	logic              free_found_q;
	logic [IW-1:0]     free_idx_q;
	logic [IW-1:0]     best_idx_q;
	logic [AGE_BITS-1:0] best_age_q;
	tag_t              best_tag_q;
	rsp_t              rsp_q;

	logic              used_s1;
	logic              match_s1;
	logic              evict;
	logic [IW-1:0]     chosen;
	tag_t              new_tag;
	logic [AGE_BITS-1:0] age_inc;

	// Compare the slot read last cycle
	assign used_s1  = used_q[idx_s1];
	assign match_s1 = used_s1 && tag_s1.file_valid && (req_q.command == CMD_FETCH) &&
		(tag_s1.table_id == req_q.table_id) && (tag_s1.file_id == req_q.file_id) &&
		(tag_s1.block_offset == req_q.block_offset);
	assign age_inc  = (age_s1 == AGE_MAX) ? age_s1 : age_s1 + AGE_BITS'(1);

	// Pick the granted slot and build its new tag
	assign evict  = !hit_found_q && !free_found_q;
	assign chosen = hit_found_q ? hit_idx_q : (free_found_q ? free_idx_q : best_idx_q);

	always_comb begin
		new_tag          = '0;
		new_tag.table_id = req_q.table_id;
		if (req_q.command == CMD_BLANK) begin
			// Keep the evicted slot's stored offset; a never-used slot gets zero
			new_tag.block_offset = free_found_q ? 24'd0 : best_tag_q.block_offset;
		end else begin
			new_tag.file_id      = req_q.file_id;
			new_tag.file_valid   = 1'b1;
			new_tag.block_offset = req_q.block_offset;
		end
	end

	assign stat.last = (cnt_q == IW'(SLOTS - 1));

	// Read and write the slot memories
	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			tag_s1 <= tag_mem[cnt_q];
			age_s1 <= age_mem[cnt_q];
		end
		if (cmd.commit) begin
			age_mem[chosen] <= '0;
		end else if (rd_valid_s1) begin
			age_mem[idx_s1] <= age_inc;
		end
		if (cmd.commit && !hit_found_q) begin
			tag_mem[chosen] <= new_tag;
		end
	end

	// Track occupancy; slots never become free again
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.scan;
			if (cmd.commit) begin
				used_q[chosen] <= 1'b1;
			end
		end
	end

	// Latch the request, advance the scan and update the trackers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q        <= req;
			cnt_q        <= '0;
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
		end
		if (cmd.scan) begin
			cnt_q  <= cnt_q + IW'(1);
			idx_s1 <= cnt_q;
		end
		if (rd_valid_s1) begin
			if (match_s1 && !hit_found_q) begin
				hit_found_q <= 1'b1;
				hit_idx_q   <= idx_s1;
			end
			if (!used_s1 && !free_found_q) begin
				free_found_q <= 1'b1;
				free_idx_q   <= idx_s1;
			end
			if ((idx_s1 == '0) || (age_s1 > best_age_q)) begin
				best_idx_q <= idx_s1;
				best_age_q <= age_s1;
				best_tag_q <= tag_s1;
			end
		end
		if (cmd.commit) begin
			rsp_q.slot     <= SLOT_W'(chosen);
			rsp_q.hit      <= hit_found_q;
			rsp_q.replaced <= evict;
			if (evict) begin
				rsp_q.old_table_id     <= best_tag_q.table_id;
				rsp_q.old_file_id      <= best_tag_q.file_id;
				rsp_q.old_block_offset <= best_tag_q.block_offset;
			end else begin
				rsp_q.old_table_id     <= '0;
				rsp_q.old_file_id      <= '0;
				rsp_q.old_block_offset <= '0;
			end
		end
	end

	assign rsp = rsp_q;

endmodule

// File: design/lru_buffer_slot_manager_core.sv
// LRU buffer slot manager, top level.
// Joins the sequencing controller and the slot datapath; depends on lbsm_pkg.
//
// Usage:
//   A request transfer happens on a rising edge with start high and busy low;
//   req carries command, table_id, file_id and block_offset. Every request
//   yields one result: done is high for exactly one cycle while rsp holds the
//   granted slot, hit/replaced flags and the displaced tag on an eviction.
// Timing:
//   The scan reads one slot per cycle from the tag and age memories, then
//   passes through a last-compare state and a commit state; done is
//   registered from the commit state.
//   busy drops in the cycle done rises, so the next request can be accepted
//   on the edge that takes the result; no new request is accepted while a
//   request is still in progress.
// Reset:
//   arst_n clears the used bits and the controller; every slot is free after
//   reset and no scan of the memories is needed. The receiver cannot stall:
//   a result must be taken in its done cycle.
module lru_buffer_slot_manager_core import lbsm_pkg::*; #(
	parameter int SLOTS    = 16,
	parameter int AGE_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	cmd_t  cmd;
	stat_t stat;

	lbsm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	lbsm_datapath #(
		.SLOTS    (SLOTS),
		.AGE_BITS (AGE_BITS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule

// File: design/lbsm_checker.sv
// Port-level checks for the LRU buffer slot manager.
// Bound to lru_buffer_slot_manager_core; depends on lbsm_pkg.
module lbsm_checker import lbsm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input req_t req,
	input logic done,
	input rsp_t rsp
);

	// An accepted request makes the block busy next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after request transfer");

	// A result is shown only once the block is idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// Finishing a request always produces its result
	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("request finished without a result");

	// A hit never evicts and reports no displaced tag
	a_hit_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.hit) |-> (!rsp.replaced && (rsp.old_table_id == '0) &&
		(rsp.old_file_id == '0) && (rsp.old_block_offset == '0)))
		else $error("hit reported with eviction data");

endmodule

bind lru_buffer_slot_manager_core lbsm_checker u_lbsm_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.req    (req),
	.done   (done),
	.rsp    (rsp)
);
